// ===== sv/pecs_pkg.sv =====
// ---------------------------------------------------------------------------
// pecs_pkg
// shared types and constants of the polygon edge clip stage
// ---------------------------------------------------------------------------
`default_nettype none
package pecs_pkg;

  localparam int COORD_W = 16;

  localparam logic [1:0] EDGE_LEFT   = 2'd0;
  localparam logic [1:0] EDGE_RIGHT  = 2'd1;
  localparam logic [1:0] EDGE_TOP    = 2'd2;
  localparam logic [1:0] EDGE_BOTTOM = 2'd3;

  localparam logic [2:0] REG_EDGE_SELECT = 3'd0;
  localparam logic [2:0] REG_MIN_X       = 3'd1;
  localparam logic [2:0] REG_MIN_Y       = 3'd2;
  localparam logic [2:0] REG_MAX_X       = 3'd3;
  localparam logic [2:0] REG_MAX_Y       = 3'd4;

  // one edge job handed from the front to the back
  typedef struct packed {
    logic signed [COORD_W-1:0] sx;
    logic signed [COORD_W-1:0] sy;
    logic signed [COORD_W-1:0] ex;
    logic signed [COORD_W-1:0] ey;
    logic                      s_in;
    logic                      e_in;
    logic                      do_edge;  // edge is clipped at all
    logic                      closing;  // final job of a polygon
    logic                      item_end; // last job of its input item
  } job_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic                      valid;
    logic                      done;
    logic                      run_end;
  } res_t;

endpackage
`default_nettype wire

// ===== sv/polygon_edge_clip_stage_top.sv =====
// ---------------------------------------------------------------------------
// polygon_edge_clip_stage_top
// one sutherland-hodgman clipping pass against a selectable window boundary
// ---------------------------------------------------------------------------
// Vertices stream in with tlast on the final one. Each edge that crosses the
// boundary costs a multiply and a serial restoring divide in the back end,
// which holds the back end until the intersection and, when the end vertex
// also survives, that vertex are out; an edge that does not cross skips both.
// A final item also clips the closing edge. A short job queue parts the
// vertex front end from the clipping back end.
`default_nettype none
module polygon_edge_clip_stage_top #(
  parameter int QUEUE_DEPTH = 4
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,   // vertex_x, vertex_y
  input  wire logic        in_tlast,   // is_last
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata,  // out_x, out_y
  output logic [1:0]       out_tuser,  // vertex_valid, polygon_done
  output logic             out_tlast,  // run_end
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  logic [1:0] edge_sel_r;
  logic signed [15:0] min_x_r, min_y_r, max_x_r, max_y_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      edge_sel_r <= pecs_pkg::EDGE_LEFT;
      min_x_r <= 16'sd4800;
      min_y_r <= 16'sd4800;
      max_x_r <= 16'sd9600;
      max_y_r <= 16'sd9600;
    end else if (cfg_we) begin
      case (cfg_index)
        pecs_pkg::REG_EDGE_SELECT: edge_sel_r <= cfg_data[1:0];
        pecs_pkg::REG_MIN_X:       min_x_r <= cfg_data;
        pecs_pkg::REG_MIN_Y:       min_y_r <= cfg_data;
        pecs_pkg::REG_MAX_X:       max_x_r <= cfg_data;
        pecs_pkg::REG_MAX_Y:       max_y_r <= cfg_data;
        default: ;
      endcase
    end
  end

  logic fj_v, fj_r, bj_v, bj_r, r_v;
  pecs_pkg::job_t fj, bj;
  pecs_pkg::res_t r;

  pecs_front u_front (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_tvalid), .in_ready(in_tready),
    .vx(in_tdata[15:0]), .vy(in_tdata[31:16]), .last(in_tlast),
    .edge_sel(edge_sel_r), .min_x(min_x_r), .min_y(min_y_r),
    .max_x(max_x_r), .max_y(max_y_r),
    .job_valid(fj_v), .job_ready(fj_r), .job(fj)
  );

  pecs_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk(clk), .rst_n(rst_n),
    .wr_valid(fj_v), .wr_ready(fj_r), .wr_data(fj),
    .rd_valid(bj_v), .rd_ready(bj_r), .rd_data(bj)
  );

  pecs_back u_back (
    .clk(clk), .rst_n(rst_n),
    .job_valid(bj_v), .job_ready(bj_r), .job(bj),
    .edge_sel(edge_sel_r), .min_x(min_x_r), .min_y(min_y_r),
    .max_x(max_x_r), .max_y(max_y_r),
    .res_valid(r_v), .res_ready(out_tready), .res(r)
  );

  assign out_tvalid = r_v;
  assign out_tdata  = {r.y, r.x};
  assign out_tuser  = {r.done, r.valid};
  assign out_tlast  = r.run_end;

endmodule
`default_nettype wire

// ===== sv/pecs_front.sv =====
// ---------------------------------------------------------------------------
// pecs_front
// accepts vertices, tracks first/previous vertex, classifies edges into jobs
// ---------------------------------------------------------------------------
`default_nettype none
module pecs_front (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic signed [pecs_pkg::COORD_W-1:0] vx,
  input  wire logic signed [pecs_pkg::COORD_W-1:0] vy,
  input  wire logic                              last,
  input  wire logic [1:0]                        edge_sel,
  input  wire logic signed [pecs_pkg::COORD_W-1:0] min_x,
  input  wire logic signed [pecs_pkg::COORD_W-1:0] min_y,
  input  wire logic signed [pecs_pkg::COORD_W-1:0] max_x,
  input  wire logic signed [pecs_pkg::COORD_W-1:0] max_y,
  output logic                                   job_valid,
  input  wire logic                              job_ready,
  output pecs_pkg::job_t                         job
);

  logic signed [pecs_pkg::COORD_W-1:0] first_x_r, first_y_r, prev_x_r, prev_y_r;
  logic signed [pecs_pkg::COORD_W-1:0] last_x_r, last_y_r;
  logic have_first_r;
  logic pend_close_r, pend_close_nxt; // closing edge still to be issued

  function automatic logic inside_f(input logic [1:0] es,
                                    input logic signed [pecs_pkg::COORD_W-1:0] x,
                                    input logic signed [pecs_pkg::COORD_W-1:0] y,
                                    input logic signed [pecs_pkg::COORD_W-1:0] mnx,
                                    input logic signed [pecs_pkg::COORD_W-1:0] mny,
                                    input logic signed [pecs_pkg::COORD_W-1:0] mxx,
                                    input logic signed [pecs_pkg::COORD_W-1:0] mxy);
    logic r;
    case (es)
      pecs_pkg::EDGE_LEFT:  r = (x >= mnx);
      pecs_pkg::EDGE_RIGHT: r = (x <= mxx);
      pecs_pkg::EDGE_TOP:   r = (y <= mxy);
      default:              r = (y >= mny);
    endcase
    return r;
  endfunction

  // first vertex of the polygon as the closing edge will see it
  logic signed [pecs_pkg::COORD_W-1:0] fx, fy;
  logic close_emits;
  assign fx = have_first_r ? first_x_r : vx;
  assign fy = have_first_r ? first_y_r : vy;
  assign close_emits = inside_f(edge_sel, vx, vy, min_x, min_y, max_x, max_y) ||
                       inside_f(edge_sel, fx, fy, min_x, min_y, max_x, max_y);

  logic acc;
  assign in_ready = !pend_close_r && job_ready;
  assign acc      = in_valid && in_ready;

  always_comb begin
    job = '0;
    job_valid = 1'b0;
    pend_close_nxt = pend_close_r;
    if (pend_close_r) begin
      job_valid    = 1'b1;
      job.sx       = last_x_r;
      job.sy       = last_y_r;
      job.ex       = first_x_r;
      job.ey       = first_y_r;
      job.do_edge  = 1'b1;
      job.closing  = 1'b1;
      job.item_end = 1'b1;
      if (job_ready) pend_close_nxt = 1'b0;
    end else if (in_valid) begin
      job_valid    = 1'b1;
      job.sx       = prev_x_r;
      job.sy       = prev_y_r;
      job.ex       = vx;
      job.ey       = vy;
      job.do_edge  = have_first_r;
      // a closing edge that yields nothing ends the polygon on this job
      job.closing  = last && !close_emits;
      job.item_end = !last || !close_emits;
      if (acc && last && close_emits) pend_close_nxt = 1'b1;
    end
    job.s_in = inside_f(edge_sel, job.sx, job.sy, min_x, min_y, max_x, max_y);
    job.e_in = inside_f(edge_sel, job.ex, job.ey, min_x, min_y, max_x, max_y);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_first_r <= 1'b0;
      pend_close_r <= 1'b0;
      first_x_r <= '0;
      first_y_r <= '0;
      prev_x_r  <= '0;
      prev_y_r  <= '0;
    end else begin
      pend_close_r <= pend_close_nxt;
      if (acc) begin
        prev_x_r <= vx;
        prev_y_r <= vy;
        last_x_r <= vx;
        last_y_r <= vy;
        if (!have_first_r) begin
          first_x_r <= vx;
          first_y_r <= vy;
        end
        have_first_r <= !last;
      end
    end
  end

endmodule
`default_nettype wire

// ===== sv/pecs_queue.sv =====
// ---------------------------------------------------------------------------
// pecs_queue
// short fifo of edge jobs between front and back
// ---------------------------------------------------------------------------
`default_nettype none
module pecs_queue #(
  parameter int DEPTH = 4
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           wr_valid,
  output logic                wr_ready,
  input  wire pecs_pkg::job_t wr_data,
  output logic                rd_valid,
  input  wire logic           rd_ready,
  output pecs_pkg::job_t      rd_data
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  pecs_pkg::job_t mem_r [DEPTH];
  logic [AW-1:0] wp_r, rp_r;
  logic [AW:0]   cnt_r;
  logic wr, rd;

  assign wr_ready = (cnt_r != (AW+1)'(DEPTH));
  assign rd_valid = (cnt_r != '0);
  assign rd_data  = mem_r[rp_r];
  assign wr = wr_valid && wr_ready;
  assign rd = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (wr) mem_r[wp_r] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
    end else begin
      if (wr) wp_r <= (wp_r == AW'(DEPTH-1)) ? '0 : wp_r + 1'b1;
      if (rd) rp_r <= (rp_r == AW'(DEPTH-1)) ? '0 : rp_r + 1'b1;
      cnt_r <= cnt_r + (AW+1)'(wr) - (AW+1)'(rd);
    end
  end

endmodule
`default_nettype wire

// ===== sv/pecs_back.sv =====
// ---------------------------------------------------------------------------
// pecs_back
// clips one edge job: serial intersection divide and result sequencing
// ---------------------------------------------------------------------------
`default_nettype none
module pecs_back (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              job_valid,
  output logic                                   job_ready,
  input  wire pecs_pkg::job_t                    job,
  input  wire logic [1:0]                        edge_sel,
  input  wire logic signed [pecs_pkg::COORD_W-1:0] min_x,
  input  wire logic signed [pecs_pkg::COORD_W-1:0] min_y,
  input  wire logic signed [pecs_pkg::COORD_W-1:0] max_x,
  input  wire logic signed [pecs_pkg::COORD_W-1:0] max_y,
  output logic                                   res_valid,
  input  wire logic                              res_ready,
  output pecs_pkg::res_t                         res
);

  localparam int W  = pecs_pkg::COORD_W;
  localparam int PW = 2*W + 2;   // product magnitude bits
  localparam int DW = W + 1;     // divisor magnitude bits

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MUL  = 3'd1;
  localparam logic [2:0] ST_DIV  = 3'd2;
  localparam logic [2:0] ST_FIN  = 3'd3;
  localparam logic [2:0] ST_OUT  = 3'd4;

  logic [2:0] st_r;
  pecs_pkg::job_t j_r;
  logic signed [W:0] da_r, db_r, dn_r;
  logic signed [W-1:0] b0_r, bnd_r;
  logic [PW-1:0] q_r;
  logic [DW:0]   rem_r;
  logic [DW-1:0] dv_r;
  logic neg_r;
  logic [5:0] cnt_r;
  logic signed [W-1:0] ix_r, iy_r;
  logic phase_r;                 // 0 intersection pending, 1 end vertex pending

  // output register
  pecs_pkg::res_t ob_r;
  logic ob_v_r;
  assign res = ob_r;
  assign res_valid = ob_v_r;
  logic ob_free;
  assign ob_free = !ob_v_r || res_ready;

  assign job_ready = (st_r == ST_IDLE);

  logic xaxis;
  assign xaxis = (edge_sel == pecs_pkg::EDGE_LEFT) || (edge_sel == pecs_pkg::EDGE_RIGHT);

  logic signed [2*W+2:0] prod;
  assign prod = db_r * dn_r;

  logic [DW:0] rsh;
  assign rsh = {rem_r[DW-1:0], q_r[PW-1]};

  logic signed [PW:0] qs;
  assign qs  = neg_r ? -$signed({1'b0, q_r}) : $signed({1'b0, q_r});

  logic need_x, need_e, ob_load;

  always_comb begin
    need_x = (j_r.s_in != j_r.e_in) && !phase_r;
    need_e = j_r.e_in;
    ob_load = (st_r == ST_OUT) && ob_free &&
              ((j_r.do_edge && (need_x || need_e)) || j_r.closing);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
      ob_v_r <= 1'b0;
      phase_r <= 1'b0;
    end else begin
      ob_v_r <= ob_load || (ob_v_r && !res_ready);
      case (st_r)
        ST_IDLE: begin
          if (job_valid) begin
            j_r <= job;
            phase_r <= 1'b0;
            if (xaxis) begin
              da_r  <= (W+1)'(job.ex) - (W+1)'(job.sx);
              b0_r  <= job.sy;
              db_r  <= (W+1)'(job.ey) - (W+1)'(job.sy);
              bnd_r <= (edge_sel == pecs_pkg::EDGE_LEFT) ? min_x : max_x;
              dn_r  <= (W+1)'((edge_sel == pecs_pkg::EDGE_LEFT) ? min_x : max_x)
                       - (W+1)'(job.sx);
            end else begin
              da_r  <= (W+1)'(job.ey) - (W+1)'(job.sy);
              b0_r  <= job.sx;
              db_r  <= (W+1)'(job.ex) - (W+1)'(job.sx);
              bnd_r <= (edge_sel == pecs_pkg::EDGE_TOP) ? max_y : min_y;
              dn_r  <= (W+1)'((edge_sel == pecs_pkg::EDGE_TOP) ? max_y : min_y)
                       - (W+1)'(job.sy);
            end
            if (job.do_edge && (job.s_in != job.e_in)) st_r <= ST_MUL;
            else st_r <= ST_OUT;
          end
        end
        ST_MUL: begin
          // no extent along the clipped axis keeps the start coordinate
          neg_r <= (da_r == '0) ? 1'b0 : (prod[2*W+2] ^ da_r[W]);
          q_r   <= (da_r == '0) ? '0 : PW'(prod[2*W+2] ? -prod : prod);
          dv_r  <= DW'(da_r[W] ? -da_r : da_r);
          rem_r <= '0;
          cnt_r <= 6'(PW);
          st_r  <= (da_r == '0) ? ST_FIN : ST_DIV;
        end
        ST_DIV: begin
          // restoring divide, one quotient bit per cycle
          if (rsh >= {1'b0, dv_r}) begin
            rem_r <= rsh - {1'b0, dv_r};
            q_r   <= {q_r[PW-2:0], 1'b1};
          end else begin
            rem_r <= rsh;
            q_r   <= {q_r[PW-2:0], 1'b0};
          end
          cnt_r <= cnt_r - 1'b1;
          if (cnt_r == 6'd1) st_r <= ST_FIN;
        end
        ST_FIN: begin
          // saturate b0 + quotient to the coordinate range
          if ((PW+1)'(b0_r) + qs > (PW+1)'(32767)) begin
            if (xaxis) iy_r <= W'(32767); else ix_r <= W'(32767);
          end else if ((PW+1)'(b0_r) + qs < -(PW+1)'(32768)) begin
            if (xaxis) iy_r <= W'(-32768); else ix_r <= W'(-32768);
          end else begin
            if (xaxis) iy_r <= W'((PW+1)'(b0_r) + qs);
            else       ix_r <= W'((PW+1)'(b0_r) + qs);
          end
          if (xaxis) ix_r <= bnd_r; else iy_r <= bnd_r;
          st_r <= ST_OUT;
        end
        ST_OUT: begin
          if (ob_free) begin
            if (j_r.do_edge && need_x) begin
              ob_r.x <= ix_r;
              ob_r.y <= iy_r;
              ob_r.valid <= 1'b1;
              ob_r.done <= j_r.closing && !need_e;
              ob_r.run_end <= j_r.item_end && !need_e;
              phase_r <= 1'b1;
              if (!need_e) st_r <= ST_IDLE;
            end else if (j_r.do_edge && need_e) begin
              ob_r.x <= j_r.ex;
              ob_r.y <= j_r.ey;
              ob_r.valid <= 1'b1;
              ob_r.done <= j_r.closing;
              ob_r.run_end <= j_r.item_end;
              st_r <= ST_IDLE;
            end else if (j_r.closing) begin
              // nothing of the final item survives
              ob_r <= '{x: '0, y: '0, valid: 1'b0, done: 1'b1, run_end: 1'b1};
              st_r <= ST_IDLE;
            end else begin
              st_r <= ST_IDLE;
            end
          end
        end
        default: st_r <= ST_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== tb/sv/tb_polygon_edge_clip_stage_top.sv =====
// ---------------------------------------------------------------------------
// tb_polygon_edge_clip_stage_top
// self-checking bench for the polygon edge clip stage
// ---------------------------------------------------------------------------
// Polygons stream in as vertex transfers. A local clipper computes the
// surviving vertices of every edge and the flags of each result. Results are
// compared in order. Phases change the boundary and the window between
// polygons, while the block is idle.
`timescale 1ns / 100ps
`default_nettype none
module tb_polygon_edge_clip_stage_top;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic               valid;
    logic               done;
    logic               run_end;
  } clip_res_t;

  typedef struct {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic               last;
    logic               has_want;
    clip_res_t          want;
  } vec_row_t;

  localparam int CYCLE_LIMIT = 400000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        out_tlast;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  polygon_edge_clip_stage_top dut (.*);

  initial begin
    forever #1 clk = ~clk;
  end

  // clipper state
  logic [1:0]         sel_edge;
  logic signed [15:0] lo_x, lo_y, hi_x, hi_y;
  logic signed [15:0] start_x, start_y, last_x, last_y;
  logic               open_poly;

  clip_res_t clip_q[$];
  int        errors = 0;
  int        n_results = 0;
  int        n_vertices = 0;
  int        n_polys = 0;
  int        n_empty = 0;
  longint    cycles = 0;
  bit        drain_mode = 1'b0;
  bit        hold_long = 1'b0;

  function automatic bit keeps(logic signed [15:0] x, logic signed [15:0] y);
    case (sel_edge)
      pecs_pkg::EDGE_LEFT:   return x >= lo_x;
      pecs_pkg::EDGE_RIGHT:  return x <= hi_x;
      pecs_pkg::EDGE_TOP:    return y <= hi_y;
      default:               return y >= lo_y;
    endcase
  endfunction

  function automatic logic signed [15:0] line_at(longint a0, longint b0, longint a1,
                                                 longint b1, longint bound);
    longint r;
    if (a1 == a0) return b0[15:0];
    r = b0 + ((b1 - b0) * (bound - a0)) / (a1 - a0);
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return r[15:0];
  endfunction

  function automatic void push_vertex(ref clip_res_t rs[$], input logic signed [15:0] x,
                                      input logic signed [15:0] y, input logic v);
    clip_res_t r;
    r = '{x: x, y: y, valid: v, done: 1'b0, run_end: 1'b0};
    rs.push_back(r);
  endfunction

  function automatic void clip_one_edge(ref clip_res_t rs[$],
                                        input logic signed [15:0] sx, sy, ex, ey);
    bit s_in, e_in;
    s_in = keeps(sx, sy);
    e_in = keeps(ex, ey);
    if (s_in != e_in) begin
      case (sel_edge)
        pecs_pkg::EDGE_LEFT:  push_vertex(rs, lo_x, line_at(sx, sy, ex, ey, lo_x), 1'b1);
        pecs_pkg::EDGE_RIGHT: push_vertex(rs, hi_x, line_at(sx, sy, ex, ey, hi_x), 1'b1);
        pecs_pkg::EDGE_TOP:   push_vertex(rs, line_at(sy, sx, ey, ex, hi_y), hi_y, 1'b1);
        default:              push_vertex(rs, line_at(sy, sx, ey, ex, lo_y), lo_y, 1'b1);
      endcase
    end
    if (e_in) push_vertex(rs, ex, ey, 1'b1);
  endfunction

  function automatic void clip_vertex(input logic signed [15:0] x, y, input logic last,
                                     ref clip_res_t rs[$]);
    rs.delete();
    if (!open_poly) begin
      start_x = x;
      start_y = y;
      open_poly = 1'b1;
    end else begin
      clip_one_edge(rs, last_x, last_y, x, y);
    end
    last_x = x;
    last_y = y;
    if (last) begin
      clip_one_edge(rs, x, y, start_x, start_y);
      if (rs.size() == 0) push_vertex(rs, 16'sd0, 16'sd0, 1'b0);
      rs[rs.size()-1].done = 1'b1;
      open_poly = 1'b0;
    end
    if (rs.size() > 0) rs[rs.size()-1].run_end = 1'b1;
  endfunction

  task automatic idle_gap(bit allow);
    if (allow && !drain_mode && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk);
    end
  endtask

  task automatic write_reg(logic [2:0] idx, logic [15:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      pecs_pkg::REG_EDGE_SELECT: sel_edge = val[1:0];
      pecs_pkg::REG_MIN_X:       lo_x = val;
      pecs_pkg::REG_MIN_Y:       lo_y = val;
      pecs_pkg::REG_MAX_X:       hi_x = val;
      pecs_pkg::REG_MAX_Y:       hi_y = val;
      default: ;
    endcase
  endtask

  task automatic wait_quiet();
    in_tvalid <= 1'b0;
    while (clip_q.size() != 0) @(negedge clk);
    repeat (80) @(negedge clk);
  endtask

  // drive one vertex; expectations are queued at the accepting edge
  task automatic send_vertex(logic signed [15:0] x, logic signed [15:0] y, logic last,
                             bit has_want, clip_res_t want);
    clip_res_t rs[$];
    idle_gap(1'b1);
    in_tvalid <= 1'b1;
    in_tdata <= {y, x};
    in_tlast <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    clip_vertex(x, y, last, rs);
    if (has_want && (rs.size() != 1 || rs[0] !== want)) begin
      errors++;
      $display("%0t directed row: expected %p, predicted %p", $time, want, rs);
    end
    foreach (rs[i]) clip_q.push_back(rs[i]);
    n_vertices++;
    if (last) n_polys++;
    @(negedge clk);
  endtask

  task automatic send_polygon(int nv, int spread);
    clip_res_t none;
    none = '0;
    for (int i = 0; i < nv; i++)
      send_vertex(16'($urandom_range(0, 2*spread) - spread + 7200),
                  16'($urandom_range(0, 2*spread) - spread + 7200), i == nv-1, 1'b0,
                  none);
  endtask

  // result checker
  always @(posedge clk) begin
    clip_res_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = '{x: out_tdata[15:0], y: out_tdata[31:16], valid: out_tuser[0],
              done: out_tuser[1], run_end: out_tlast};
      n_results++;
      if (!got.valid) n_empty++;
      if (clip_q.size() == 0) begin
        errors++;
        $display("%0t unexpected transfer: actual %p", $time, got);
      end else begin
        want = clip_q.pop_front();
        if (got.x !== want.x || got.y !== want.y || got.valid !== want.valid ||
            got.done !== want.done || got.run_end !== want.run_end) begin
          errors++;
          $display("%0t mismatch: expected %p, actual %p", $time, want, got);
        end
      end
    end
  end

  // receiver with random stalls and one long hold-off
  initial begin
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_long) begin
        out_tready <= 1'b0;
        repeat (600) @(negedge clk);
        hold_long = 1'b0;
      end else if (!drain_mode && $urandom_range(0, 7) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(negedge clk);
      end
      out_tready <= 1'b1;
    end
  end

  initial begin
    @(posedge clk);
    while (cycles < CYCLE_LIMIT) @(posedge clk) cycles++;
    $display("timeout after %0d cycles", cycles);
    $display("tb_polygon_edge_clip_stage_top: FAIL");
    $finish;
  end

  vec_row_t  dir_rows[$];
  clip_res_t empty_res;

  function automatic vec_row_t row(logic signed [15:0] x, y, logic last, bit hw,
                                   clip_res_t w);
    vec_row_t r;
    r = '{x: x, y: y, last: last, has_want: hw, want: w};
    return r;
  endfunction

  initial begin
    logic [1:0] edges[4];
    sel_edge = pecs_pkg::EDGE_LEFT;
    lo_x = 16'sd4800; lo_y = 16'sd4800; hi_x = 16'sd9600; hi_y = 16'sd9600;
    start_x = '0; start_y = '0; last_x = '0; last_y = '0; open_poly = 1'b0;
    empty_res = '{x: 16'sd0, y: 16'sd0, valid: 1'b0, done: 1'b1, run_end: 1'b1};

    repeat (2) @(negedge clk);
    rst_n <= 1'b1;

    // directed, reset window, left boundary
    dir_rows.push_back(row(16'sh8000, 16'sh8000, 1'b1, 1'b1, empty_res));   // lone outside
    dir_rows.push_back(row(16'sd7000, 16'sd100, 1'b1, 1'b1,
                           '{16'sd7000, 16'sd100, 1'b1, 1'b1, 1'b1}));      // lone inside
    dir_rows.push_back(row(16'sh7fff, 16'sh7fff, 1'b1, 1'b1,
                           '{16'sh7fff, 16'sh7fff, 1'b1, 1'b1, 1'b1}));
    dir_rows.push_back(row(16'sd1000, 16'sd1000, 1'b0, 1'b0, empty_res));   // crossing square
    dir_rows.push_back(row(16'sd8000, 16'sd1000, 1'b0, 1'b0, empty_res));
    dir_rows.push_back(row(16'sd8000, 16'sd8000, 1'b0, 1'b0, empty_res));
    dir_rows.push_back(row(16'sd1000, 16'sd8000, 1'b1, 1'b0, empty_res));
    dir_rows.push_back(row(16'sh8000, 16'sh7fff, 1'b0, 1'b0, empty_res));   // extreme crossing
    dir_rows.push_back(row(16'sh7fff, 16'sh8000, 1'b1, 1'b0, empty_res));
    dir_rows.push_back(row(16'sd0, 16'sd0, 1'b0, 1'b0, empty_res));         // outside, no result
    dir_rows.push_back(row(16'sd10, 16'sd5, 1'b0, 1'b0, empty_res));
    dir_rows.push_back(row(16'sd4800, 16'sd0, 1'b1, 1'b0, empty_res));      // on the boundary
    foreach (dir_rows[i])
      send_vertex(dir_rows[i].x, dir_rows[i].y, dir_rows[i].last,
                  dir_rows[i].has_want, dir_rows[i].want);
    wait_quiet();

    // each boundary in turn, extreme windows among them
    edges = '{pecs_pkg::EDGE_LEFT, pecs_pkg::EDGE_RIGHT, pecs_pkg::EDGE_TOP,
              pecs_pkg::EDGE_BOTTOM};
    for (int ph = 0; ph < 8; ph++) begin
      write_reg(pecs_pkg::REG_EDGE_SELECT, 16'(edges[ph % 4]));
      if (ph == 4) begin
        write_reg(pecs_pkg::REG_MIN_X, 16'h8000); write_reg(pecs_pkg::REG_MIN_Y, 16'h8000);
        write_reg(pecs_pkg::REG_MAX_X, 16'h7fff); write_reg(pecs_pkg::REG_MAX_Y, 16'h7fff);
      end else if (ph == 5) begin
        write_reg(pecs_pkg::REG_MIN_X, 16'h7fff); write_reg(pecs_pkg::REG_MIN_Y, 16'h7fff);
        write_reg(pecs_pkg::REG_MAX_X, 16'h8000); write_reg(pecs_pkg::REG_MAX_Y, 16'h8000);
      end else if (ph >= 1) begin
        write_reg(pecs_pkg::REG_MIN_X, 16'(7200 - $urandom_range(0, 3000)));
        write_reg(pecs_pkg::REG_MIN_Y, 16'(7200 - $urandom_range(0, 3000)));
        write_reg(pecs_pkg::REG_MAX_X, 16'(7200 + $urandom_range(0, 3000)));
        write_reg(pecs_pkg::REG_MAX_Y, 16'(7200 + $urandom_range(0, 3000)));
      end
      if (ph == 2) hold_long = 1'b1;      // receiver holds off, block backs up
      if (ph == 7) drain_mode = 1'b1;     // no idling at the tail
      for (int p = 0; p < 5; p++) begin
        if ($urandom_range(0, 9) == 0) send_polygon($urandom_range(1, 6), 32767);
        else send_polygon($urandom_range(1, 6), $urandom_range(100, 6000));
      end
      if (ph == 3) wait_quiet();          // sender pauses until all results are in
      wait_quiet();
    end

    $display("covered %0d vertices in %0d polygons, %0d results (%0d empty polygons),",
             n_vertices, n_polys, n_results, n_empty);
    $display("all four boundaries and extreme windows, with stalls on both sides");
    if (errors == 0) begin
      $display("tb_polygon_edge_clip_stage_top: PASS");
    end else begin
      $display("tb_polygon_edge_clip_stage_top: FAIL");
    end
    $finish;
  end

endmodule
`default_nettype wire
